FILE: rtl/llnp_pkg.sv
package llnp_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam int LOAD_W    = 24;
  localparam int MEM_W     = 20;
  localparam int SPEED_W   = 16;
  localparam int CPUS_W    = 8;
  localparam int RAND_W    = 16;
  localparam int NCFG_W    = 7;
  localparam int PROD_W    = SPEED_W + CPUS_W;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  localparam int                LOAD_SCALE = 1000000;

  // Shared divider: dividend and divisor widths
  localparam int DIVD_W = 20;
  localparam int DIVS_W = PROD_W;

  // Table word: {load, free memory, scaled reciprocal}
  localparam int ENTRY_W = LOAD_W + MEM_W + LOAD_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_PER_PROC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_MARGIN = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_CHOOSE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_W_GO,
    S_W_DIV,
    S_W_WR,
    S_C_P1,
    S_C_P2,
    S_C_MGO,
    S_C_MOD,
    S_C_P3
  } state_t;

endpackage

FILE: rtl/llnp_ram.sv
module llnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/llnp_div.sv
module llnp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [llnp_pkg::DIVD_W-1:0] dividend,
  input  logic [llnp_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [llnp_pkg::DIVD_W-1:0] quotient,
  output logic [llnp_pkg::DIVS_W-1:0] remainder
);
  import llnp_pkg::*;

  localparam int IT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [IT_W-1:0]   it_r;
  logic              run_r;
  logic              done_r;
  logic [DIVS_W:0]   trial;
  logic              take;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        it_r  <= IT_W'(DIVD_W);
      end else if (run_r) begin
        it_r <= it_r - 1'b1;
        if (it_r == IT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (take) begin
        rem_r <= DIVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[DIVS_W-1:0];
      end
      quo_r <= {quo_r[DIVD_W-2:0], take};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/least_loaded_node_picker.sv
// Least-loaded node picker: one result word per accepted item, strobed by out_valid.
// Write item: a 20-step reciprocal divide, then the table write and the result word.
// Choose item: up to three scans of the single-read-port table (one entry per cycle) and a
// 20-step modulo on the shared divider. One item at a time; busy is high from accept
// until the result cycle. The receiver cannot stall. Reset (synchronous, rst_n low)
// clears control and configuration, but sets the load margin to 5.
module least_loaded_node_picker (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [5:0]                    in_node_index,
  input  logic [llnp_pkg::MEM_W-1:0]    in_load_in,
  input  logic [llnp_pkg::MEM_W-1:0]    in_free_mem_in,
  input  logic [llnp_pkg::SPEED_W-1:0]  in_speed_in,
  input  logic [llnp_pkg::CPUS_W-1:0]   in_cpus_in,
  input  logic [llnp_pkg::RAND_W-1:0]   in_random_in,
  // result channel
  output logic                          out_valid,
  output logic [5:0]                    out_chosen_index,
  output logic                          out_found,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [llnp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llnp_pkg::MEM_W-1:0]    cfg_data
);
  import llnp_pkg::*;

  // configuration registers
  logic [NCFG_W-1:0] node_count_r;
  logic [MEM_W-1:0]  mem_per_proc_r;
  logic [MEM_W-1:0]  margin_r;
  logic [CNT_W-1:0]  n_eff;

  state_t state_r, state_nxt;

  // captured command word
  logic              idx_ok_r;
  logic [IDX_W-1:0]  widx_r;
  logic [MEM_W-1:0]  wload_r;
  logic [MEM_W-1:0]  wfree_r;
  logic [PROD_W-1:0] prod_r;
  logic [RAND_W-1:0] rand_r;

  // scan pipeline
  logic [CNT_W-1:0]  scan_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              issue;
  logic              scan_clr;
  logic              scan_end;

  // choose bookkeeping
  logic              any_r, any_nxt;
  logic [LOAD_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;

  // table
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic [IDX_W-1:0]   waddr;
  logic               we;

  // entry decode
  logic [LOAD_W-1:0] e_load;
  logic [MEM_W-1:0]  e_free;
  logic [LOAD_W-1:0] e_q;
  logic [LOAD_W:0]   e_sum;
  logic [LOAD_W-1:0] e_fut;
  logic              e_fits;
  logic              e_near;

  // divider
  logic              div_start;
  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;
  logic [DIVS_W-1:0] div_rem;
  logic [LOAD_W-1:0] recip;

  // result word
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_found_r, out_found_nxt;

  logic accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // a count above the table depth acts as the full table
  assign n_eff = (32'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r   <= '0;
      mem_per_proc_r <= '0;
      margin_r       <= MEM_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NODE_COUNT) begin
        node_count_r <= cfg_data[NCFG_W-1:0];
      end else if (cfg_index == REG_MEM_PER_PROC) begin
        mem_per_proc_r <= cfg_data;
      end else if (cfg_index == REG_LOAD_MARGIN) begin
        margin_r <= cfg_data;
      end
    end
  end

  // capture the command word; the multiply feeds the divisor
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_ok_r <= (32'(in_node_index) < MAX_NODES);
      widx_r   <= IDX_W'(in_node_index);
      wload_r  <= in_load_in;
      wfree_r  <= in_free_mem_in;
      prod_r   <= in_speed_in * in_cpus_in;
      rand_r   <= in_random_in;
    end
  end

  // future load of the entry coming out of the table
  assign e_load = rdata[ENTRY_W-1 -: LOAD_W];
  assign e_free = rdata[LOAD_W +: MEM_W];
  assign e_q    = rdata[LOAD_W-1:0];
  assign e_sum  = {1'b0, e_load} + {1'b0, e_q};
  assign e_fut  = e_sum[LOAD_W] ? LOAD_MAX : e_sum[LOAD_W-1:0];
  assign e_fits = e_free > mem_per_proc_r;
  assign e_near = (e_fut - best_r) <= LOAD_W'(margin_r);

  // zero product saturates the future load
  assign recip = (prod_r == '0) ? LOAD_MAX : LOAD_W'(div_quo);

  assign div_dvd = (state_r == S_C_MGO) ? DIVD_W'(rand_r) : DIVD_W'(LOAD_SCALE);
  assign div_dvs = (state_r == S_C_MGO) ? DIVS_W'(count_r) : prod_r;

  llnp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  llnp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign scan_end = (scan_r == n_eff) && !rd_vld_r;

  always_comb begin
    state_nxt     = state_r;
    issue         = 1'b0;
    scan_clr      = 1'b0;
    div_start     = 1'b0;
    we            = 1'b0;
    waddr         = widx_r;
    wdata         = {{(LOAD_W - MEM_W){1'b0}}, wload_r, wfree_r, recip};
    any_nxt       = any_r;
    best_nxt      = best_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_clr  = 1'b1;
          any_nxt   = 1'b0;
          count_nxt = '0;
          state_nxt = (in_op == OP_WRITE) ? S_W_GO : S_C_P1;
        end
      end
      S_W_GO: begin
        div_start = 1'b1;
        state_nxt = S_W_DIV;
      end
      S_W_DIV: begin
        if (div_done) begin
          state_nxt = S_W_WR;
        end
      end
      S_W_WR: begin
        // drop writes outside the table
        we            = idx_ok_r;
        out_valid_nxt = 1'b1;
        out_idx_nxt   = '0;
        out_found_nxt = idx_ok_r;
        state_nxt     = S_IDLE;
      end
      S_C_P1: begin
        // pass one: smallest future load among fitting entries
        issue = (scan_r < n_eff);
        if (rd_vld_r && e_fits && (!any_r || e_fut < best_r)) begin
          any_nxt  = 1'b1;
          best_nxt = e_fut;
        end
        if (scan_end) begin
          scan_clr = 1'b1;
          if (!any_r) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = '0;
            out_found_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_C_P2;
          end
        end
      end
      S_C_P2: begin
        // pass two: count the near-best entries
        issue = (scan_r < n_eff);
        if (rd_vld_r && e_fits && e_near) begin
          count_nxt = count_r + 1'b1;
        end
        if (scan_end) begin
          scan_clr  = 1'b1;
          state_nxt = S_C_MGO;
        end
      end
      S_C_MGO: begin
        div_start = 1'b1;
        state_nxt = S_C_MOD;
      end
      S_C_MOD: begin
        if (div_done) begin
          pos_nxt   = CNT_W'(div_rem) + 1'b1;
          state_nxt = S_C_P3;
        end
      end
      S_C_P3: begin
        // pass three: walk to the chosen near-best entry and update it
        issue = (scan_r < n_eff);
        waddr = rd_idx_r;
        wdata = {e_fut, e_free - mem_per_proc_r, e_q};
        if (rd_vld_r && e_fits && e_near) begin
          if (pos_r == CNT_W'(1)) begin
            we            = 1'b1;
            issue         = 1'b0;
            out_valid_nxt = 1'b1;
            out_idx_nxt   = rd_idx_r;
            out_found_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end else if (scan_end) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_found_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_r      <= '0;
      any_r       <= 1'b0;
      count_r     <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= issue;
      any_r       <= any_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      if (scan_clr) begin
        scan_r <= '0;
      end else if (issue) begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_r[IDX_W-1:0];
    best_r      <= best_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = 6'(out_idx_r);
  assign out_found        = out_found_r;

endmodule
